// File: rtl/avt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avt_pkg
// shared types and constants of the affine vertex transform
// ----------------------------------------------------------------------------
package avt_pkg;

	localparam int unsigned ROW_BITS     = 48;
	localparam int unsigned SLOT_BITS    = 16;
	localparam int unsigned COEF_FRAC    = 13;
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned TRANS_BITS   = 32;

	typedef logic [ROW_BITS-1:0] row_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LIN_ROW_X = 3'd0,
		CFG_LIN_ROW_Y = 3'd1,
		CFG_LIN_ROW_Z = 3'd2,
		CFG_TRANS_X   = 3'd3,
		CFG_TRANS_Y   = 3'd4,
		CFG_TRANS_Z   = 3'd5
	} cfg_idx_t;

	// identity matrix: 1.0 on the diagonal
	localparam row_t ROW_X_RESET = 48'h0000_0000_2000;
	localparam row_t ROW_Y_RESET = 48'h0000_2000_0000;
	localparam row_t ROW_Z_RESET = 48'h2000_0000_0000;

endpackage
`default_nettype wire

// File: rtl/affine_vertex_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_vertex_transform
// per-vertex 3x3 linear plus translation transform in signed fixed point
// ----------------------------------------------------------------------------
// Accepts one vertex per clock while in_stall is low; it leaves from the last stage. Each of
// the six output components has its own lane of three register stages:
// three signed multiplies, then sum and round to nearest, then translation
// add and saturation. The whole pipe advances together and holds only while
// a finished vertex waits at the output with out_stall high, so throughput
// is one vertex per cycle whenever the consumer takes results. Write the
// matrix and translation registers only while no vertex is in flight.
module affine_vertex_transform #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned COEF_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [avt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [avt_pkg::ROW_BITS-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [COORD_BITS-1:0]      pos_x,
	input  wire logic signed [COORD_BITS-1:0]      pos_y,
	input  wire logic signed [COORD_BITS-1:0]      pos_z,
	input  wire logic signed [COORD_BITS-1:0]      norm_x,
	input  wire logic signed [COORD_BITS-1:0]      norm_y,
	input  wire logic signed [COORD_BITS-1:0]      norm_z,
	input  wire logic                              vertex_last,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [COORD_BITS-1:0]           out_pos_x,
	output logic signed [COORD_BITS-1:0]           out_pos_y,
	output logic signed [COORD_BITS-1:0]           out_pos_z,
	output logic signed [COORD_BITS-1:0]           out_norm_x,
	output logic signed [COORD_BITS-1:0]           out_norm_y,
	output logic signed [COORD_BITS-1:0]           out_norm_z,
	output logic                                   sat_flag,
	output logic                                   out_last
);
	import avt_pkg::*;

	row_t                         row_x, row_y, row_z;
	logic signed [COORD_BITS-1:0] trans_x, trans_y, trans_z;
	logic                         en;
	logic                         v_s1, v_s2, v_s3;
	logic                         last_s1, last_s2, last_s3;
	logic [5:0]                   sat;

	assign cfg_ready = 1'b1;

	avt_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.row_x    (row_x),
		.row_y    (row_y),
		.row_z    (row_z),
		.trans_x  (trans_x),
		.trans_y  (trans_y),
		.trans_z  (trans_z)
	);

	// whole pipe moves unless the output item is held
	assign en       = !(v_s3 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= vertex_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_pos_x (
		.clk(clk), .en(en), .vec_x(pos_x), .vec_y(pos_y), .vec_z(pos_z),
		.row(row_x), .offs(trans_x), .res(out_pos_x), .sat(sat[0])
	);

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_pos_y (
		.clk(clk), .en(en), .vec_x(pos_x), .vec_y(pos_y), .vec_z(pos_z),
		.row(row_y), .offs(trans_y), .res(out_pos_y), .sat(sat[1])
	);

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_pos_z (
		.clk(clk), .en(en), .vec_x(pos_x), .vec_y(pos_y), .vec_z(pos_z),
		.row(row_z), .offs(trans_z), .res(out_pos_z), .sat(sat[2])
	);

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_norm_x (
		.clk(clk), .en(en), .vec_x(norm_x), .vec_y(norm_y), .vec_z(norm_z),
		.row(row_x), .offs('0), .res(out_norm_x), .sat(sat[3])
	);

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_norm_y (
		.clk(clk), .en(en), .vec_x(norm_x), .vec_y(norm_y), .vec_z(norm_z),
		.row(row_y), .offs('0), .res(out_norm_y), .sat(sat[4])
	);

	avt_dot3 #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS)) u_norm_z (
		.clk(clk), .en(en), .vec_x(norm_x), .vec_y(norm_y), .vec_z(norm_z),
		.row(row_z), .offs('0), .res(out_norm_z), .sat(sat[5])
	);

	assign out_valid = v_s3;
	assign sat_flag  = |sat;
	assign out_last  = last_s3;

endmodule
`default_nettype wire

// File: rtl/avt_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avt_cfg
// matrix and translation registers written through the config port
// ----------------------------------------------------------------------------
module avt_cfg #(
	parameter int unsigned COORD_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [avt_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [avt_pkg::ROW_BITS-1:0]      wr_data,
	output avt_pkg::row_t                          row_x,
	output avt_pkg::row_t                          row_y,
	output avt_pkg::row_t                          row_z,
	output logic signed [COORD_BITS-1:0]           trans_x,
	output logic signed [COORD_BITS-1:0]           trans_y,
	output logic signed [COORD_BITS-1:0]           trans_z
);
	import avt_pkg::*;

	localparam int unsigned TW = (COORD_BITS < TRANS_BITS) ? COORD_BITS : TRANS_BITS;

	row_t                    row_x_q, row_y_q, row_z_q;
	logic [COORD_BITS-1:0]   trans_x_q, trans_y_q, trans_z_q;
	logic [COORD_BITS-1:0]   trans_wr;

	// translation keeps at most 32 written bits
	assign trans_wr = COORD_BITS'(wr_data[TW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q   <= ROW_X_RESET;
			row_y_q   <= ROW_Y_RESET;
			row_z_q   <= ROW_Z_RESET;
			trans_x_q <= '0;
			trans_y_q <= '0;
			trans_z_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LIN_ROW_X: row_x_q   <= wr_data;
				CFG_LIN_ROW_Y: row_y_q   <= wr_data;
				CFG_LIN_ROW_Z: row_z_q   <= wr_data;
				CFG_TRANS_X:   trans_x_q <= trans_wr;
				CFG_TRANS_Y:   trans_y_q <= trans_wr;
				CFG_TRANS_Z:   trans_z_q <= trans_wr;
				default: ;
			endcase
		end
	end

	assign row_x   = row_x_q;
	assign row_y   = row_y_q;
	assign row_z   = row_z_q;
	assign trans_x = signed'(trans_x_q);
	assign trans_y = signed'(trans_y_q);
	assign trans_z = signed'(trans_z_q);

endmodule
`default_nettype wire

// File: rtl/avt_dot3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avt_dot3
// three-stage dot product lane: multiply, sum and round, offset and saturate
// ----------------------------------------------------------------------------
module avt_dot3 #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned COEF_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [COORD_BITS-1:0]  vec_x,
	input  wire logic signed [COORD_BITS-1:0]  vec_y,
	input  wire logic signed [COORD_BITS-1:0]  vec_z,
	input  wire logic [avt_pkg::ROW_BITS-1:0]  row,
	input  wire logic signed [COORD_BITS-1:0]  offs,
	output logic signed [COORD_BITS-1:0]       res,
	output logic                               sat
);
	import avt_pkg::*;

	localparam int unsigned PW = COORD_BITS + COEF_BITS;
	localparam int unsigned SW = PW + 2;
	localparam int unsigned RW = SW - COEF_FRAC;
	localparam int unsigned TW = RW + 1;
	localparam logic signed [SW-1:0] RND  = SW'(1) << (COEF_FRAC - 1);
	localparam logic signed [TW-1:0] MAXV = TW'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [TW-1:0] MINV = -MAXV - TW'(1);

	logic signed [COEF_BITS-1:0]  coef [3];
	logic signed [COORD_BITS-1:0] vec  [3];
	logic signed [PW-1:0]         prod_s1 [3];
	logic signed [SW-1:0]         sum;
	logic signed [RW-1:0]         sum_s2;
	logic signed [TW-1:0]         tot;
	logic signed [COORD_BITS-1:0] res_s3;
	logic                         sat_s3;

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			coef[k] = signed'(row[k*SLOT_BITS +: COEF_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= PW'(vec[k]) * PW'(coef[k]);
			end
		end
	end

	// round to nearest, ties up
	assign sum = SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]) + RND;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= RW'(sum >>> COEF_FRAC);
		end
	end

	assign tot = TW'(sum_s2) + TW'(offs);

	always_ff @(posedge clk) begin
		if (en) begin
			if (tot > MAXV) begin
				res_s3 <= COORD_BITS'(MAXV);
				sat_s3 <= 1'b1;
			end else if (tot < MINV) begin
				res_s3 <= COORD_BITS'(MINV);
				sat_s3 <= 1'b1;
			end else begin
				res_s3 <= COORD_BITS'(tot);
				sat_s3 <= 1'b0;
			end
		end
	end

	assign res = res_s3;
	assign sat = sat_s3;

endmodule
`default_nettype wire

// File: sim/tb_affine_vertex_transform.sv
// ----------------------------------------------------------------------------
// tb_affine_vertex_transform
// self-checking testbench of the affine vertex transform
// ----------------------------------------------------------------------------
// Writes the matrix and translation registers while the pipe is empty, then
// streams vertices through it. A directed table covers identity passthrough,
// extreme coefficients and coordinates, saturation in both directions and
// round-half-up ties. Random phases then use random matrices and vertices.
// Every result is compared field by field with an in-order queue filled by a
// fixed-point predictor, or by the input for identity rows. Both sides idle at random,
// with one phase without idling and one long output hold that backs up the pipe.
// ----------------------------------------------------------------------------
module tb_affine_vertex_transform;
	import avt_pkg::*;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t px, py, pz, nx, ny, nz;
		logic   last;
	} vertex_t;

	typedef struct packed {
		coord_t px, py, pz, nx, ny, nz;
		logic   sat;
		logic   last;
	} xform_t;

	typedef enum logic [2:0] {
		MAT_IDENTITY,
		MAT_GAIN_MAX,
		MAT_GAIN_MIN,
		MAT_HALF,
		MAT_RANDOM
	} mat_preset_t;

	typedef struct packed {
		mat_preset_t mat;
		logic        typed;
		vertex_t     v;
	} dir_row_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;

	localparam coord_t C_ZERO    = 32'sh0000_0000;
	localparam coord_t C_MAX     = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN     = 32'sh8000_0000;
	localparam coord_t C_ONE     = 32'sh0001_0000;
	localparam coord_t C_NEG_ONE = 32'shFFFF_0000;
	localparam coord_t C_LSB     = 32'sh0000_0001;
	localparam coord_t C_NEG_LSB = 32'shFFFF_FFFF;
	localparam coord_t C_ALT_A   = 32'shAAAA_AAAA;
	localparam coord_t C_ALT_B   = 32'sh5555_5555;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	localparam int DIR_ROWS = 17;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{MAT_IDENTITY, 1'b1, '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0}},
		'{MAT_IDENTITY, 1'b1, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1}},
		'{MAT_IDENTITY, 1'b1, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0}},
		'{MAT_IDENTITY, 1'b1, '{C_NEG_LSB, C_LSB, C_NEG_LSB, C_LSB, C_NEG_LSB, C_LSB, 1'b0}},
		'{MAT_IDENTITY, 1'b1, '{C_ONE, C_NEG_ONE, C_ONE, C_NEG_ONE, C_ONE, C_NEG_ONE, 1'b1}},
		'{MAT_IDENTITY, 1'b1, '{C_ALT_A, C_ALT_B, C_ALT_A, C_ALT_B, C_ALT_A, C_ALT_B, 1'b0}},
		'{MAT_GAIN_MAX, 1'b0, '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0}},
		'{MAT_GAIN_MAX, 1'b0, '{C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, 1'b1}},
		'{MAT_GAIN_MAX, 1'b0, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0}},
		'{MAT_GAIN_MAX, 1'b0, '{C_LSB, C_LSB, C_LSB, C_NEG_LSB, C_NEG_LSB, C_NEG_LSB, 1'b0}},
		'{MAT_GAIN_MIN, 1'b0, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1}},
		'{MAT_GAIN_MIN, 1'b0, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0}},
		'{MAT_GAIN_MIN, 1'b0, '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0}},
		'{MAT_GAIN_MIN, 1'b0, '{C_NEG_LSB, C_NEG_LSB, C_NEG_LSB, C_LSB, C_LSB, C_LSB, 1'b1}},
		'{MAT_HALF, 1'b0, '{C_LSB, C_NEG_LSB, 32'sd3, -32'sd3, 32'sd5, -32'sd5, 1'b0}},
		'{MAT_HALF, 1'b0, '{C_MAX, C_MIN, C_ONE, C_NEG_ONE, C_ALT_A, C_ALT_B, 1'b1}},
		'{MAT_IDENTITY, 1'b1, '{C_ALT_B, C_ALT_A, C_ONE, C_MIN, C_MAX, C_NEG_ONE, 1'b1}}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	row_t                    cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	coord_t                  pos_x, pos_y, pos_z;
	coord_t                  norm_x, norm_y, norm_z;
	logic                    vertex_last;
	logic                    out_valid;
	logic                    out_stall;
	coord_t                  out_pos_x, out_pos_y, out_pos_z;
	coord_t                  out_norm_x, out_norm_y, out_norm_z;
	logic                    sat_flag;
	logic                    out_last;

	row_t   gain_row [3];
	coord_t offset [3];
	xform_t xformed_q [$];
	int     err_count = 0;
	int     send_idle_pct = 27;
	int     take_idle_pct = 27;
	logic   hold_req = 1'b0;
	int     hold_left = 0;

	affine_vertex_transform u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.vertex_last (vertex_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y),
		.out_pos_z   (out_pos_z),
		.out_norm_x  (out_norm_x),
		.out_norm_y  (out_norm_y),
		.out_norm_z  (out_norm_z),
		.sat_flag    (sat_flag),
		.out_last    (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 200000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// {sat, value}: three Q3.13 products, round half up to Q16.16, offset, clamp
	function automatic logic [32:0] row_dot(input row_t row, input coord_t a,
			input coord_t b, input coord_t c, input coord_t offs);
		logic signed [15:0] k0, k1, k2;
		longint             acc;
		longint             r;
		k0  = row[15:0];
		k1  = row[31:16];
		k2  = row[47:32];
		acc = longint'(a) * longint'(k0) + longint'(b) * longint'(k1)
			+ longint'(c) * longint'(k2);
		r = ((acc + 64'sd4096) >>> COEF_FRAC) + longint'(offs);
		if (r > SAT_HI)
			return {1'b1, 32'h7FFF_FFFF};
		if (r < SAT_LO)
			return {1'b1, 32'h8000_0000};
		return {1'b0, r[31:0]};
	endfunction

	function automatic xform_t transform_vertex(input vertex_t v);
		logic [32:0] s [6];
		xform_t      t;
		for (int i = 0; i < 3; i++) begin
			s[i]     = row_dot(gain_row[i], v.px, v.py, v.pz, offset[i]);
			s[i + 3] = row_dot(gain_row[i], v.nx, v.ny, v.nz, C_ZERO);
		end
		t.px   = s[0][31:0];
		t.py   = s[1][31:0];
		t.pz   = s[2][31:0];
		t.nx   = s[3][31:0];
		t.ny   = s[4][31:0];
		t.nz   = s[5][31:0];
		t.sat  = s[0][32] | s[1][32] | s[2][32] | s[3][32] | s[4][32] | s[5][32];
		t.last = v.last;
		return t;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return C_MAX;
			1: return C_MIN;
			2, 3, 4: return coord_t'($urandom_range(200 << 16)) - (100 << 16);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3, 4, 5: return 16'($urandom_range(16384)) - 16'd8192;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_count++;
		end
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input row_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LIN_ROW_X: gain_row[0] = data;
			CFG_LIN_ROW_Y: gain_row[1] = data;
			CFG_LIN_ROW_Z: gain_row[2] = data;
			CFG_TRANS_X:   offset[0] = data[31:0];
			CFG_TRANS_Y:   offset[1] = data[31:0];
			CFG_TRANS_Z:   offset[2] = data[31:0];
			default: ;
		endcase
	endtask

	task automatic apply_preset(input mat_preset_t p);
		row_t rows [3];
		row_t tdata [3];
		for (int i = 0; i < 3; i++) begin
			case (p)
				MAT_GAIN_MAX: begin
					rows[i]  = 48'h7FFF_7FFF_7FFF;
					tdata[i] = 48'hFFFF_7FFF_FFFF;
				end
				MAT_GAIN_MIN: begin
					rows[i]  = 48'h8000_8000_8000;
					tdata[i] = 48'h1234_8000_0000;
				end
				MAT_HALF: begin
					rows[i]  = 48'h1000 << (16 * i);
					tdata[i] = '0;
				end
				MAT_RANDOM: begin
					rows[i] = {rand_coef(), rand_coef(), rand_coef()};
					case ($urandom_range(5))
						0: tdata[i] = {16'($urandom), C_MAX};
						1: tdata[i] = {16'($urandom), C_MIN};
						2, 3: tdata[i] = {16'($urandom),
							coord_t'($urandom_range(64 << 16)) - (32 << 16)};
						default: tdata[i] = {16'($urandom), 32'($urandom)};
					endcase
				end
				default: begin
					rows[i]  = (i == 0) ? ROW_X_RESET : (i == 1) ? ROW_Y_RESET : ROW_Z_RESET;
					tdata[i] = '0;
				end
			endcase
		end
		cfg_write(CFG_LIN_ROW_X, rows[0]);
		cfg_write(CFG_LIN_ROW_Y, rows[1]);
		cfg_write(CFG_LIN_ROW_Z, rows[2]);
		cfg_write(CFG_TRANS_X, tdata[0]);
		cfg_write(CFG_TRANS_Y, tdata[1]);
		cfg_write(CFG_TRANS_Z, tdata[2]);
		cfg_write(CFG_IDX_SPARE_A, {16'($urandom), 32'($urandom)});
		cfg_write(CFG_IDX_SPARE_B, {16'($urandom), 32'($urandom)});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_vertex(input vertex_t v, input xform_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pos_x       <= v.px;
		pos_y       <= v.py;
		pos_z       <= v.pz;
		norm_x      <= v.nx;
		norm_y      <= v.ny;
		norm_z      <= v.nz;
		vertex_last <= v.last;
		do @(posedge clk); while (in_stall);
		xformed_q.push_back(t);
	endtask

	// sender pauses until the pipe is empty
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (xformed_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		xform_t t;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (xformed_q.size() == 0) begin
					$error("unexpected item at output");
					err_count++;
				end else begin
					t = xformed_q.pop_front();
					check_field("out_pos_x", t.px, out_pos_x);
					check_field("out_pos_y", t.py, out_pos_y);
					check_field("out_pos_z", t.pz, out_pos_z);
					check_field("out_norm_x", t.nx, out_norm_x);
					check_field("out_norm_y", t.ny, out_norm_y);
					check_field("out_norm_z", t.nz, out_norm_z);
					check_field("sat_flag", 32'(t.sat), 32'(sat_flag));
					check_field("out_last", 32'(t.last), 32'(out_last));
				end
			end
			if (hold_req) begin
				hold_left = 40;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < take_idle_pct);
			end
		end
	end

	initial begin
		mat_preset_t cur;
		vertex_t     v;
		xform_t      t;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		pos_x       <= '0;
		pos_y       <= '0;
		pos_z       <= '0;
		norm_x      <= '0;
		norm_y      <= '0;
		norm_z      <= '0;
		vertex_last <= 1'b0;
		gain_row[0] = ROW_X_RESET;
		gain_row[1] = ROW_Y_RESET;
		gain_row[2] = ROW_Z_RESET;
		for (int i = 0; i < 3; i++)
			offset[i] = C_ZERO;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = MAT_IDENTITY;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].mat != cur) begin
				finish_phase();
				apply_preset(DIRECTED[i].mat);
				cur = DIRECTED[i].mat;
			end
			v = DIRECTED[i].v;
			if (DIRECTED[i].typed)
				t = '{v.px, v.py, v.pz, v.nx, v.ny, v.nz, 1'b0, v.last};
			else
				t = transform_vertex(v);
			send_vertex(v, t);
		end

		for (int ph = 0; ph < 10; ph++) begin
			finish_phase();
			apply_preset(MAT_RANDOM);
			send_idle_pct = (ph == 1) ? 0 : 27;
			take_idle_pct = (ph == 1) ? 0 : 27;
			for (int k = 0; k < 55; k++) begin
				if (ph == 4 && k == 6)
					hold_req = 1'b1;
				v.px   = rand_coord();
				v.py   = rand_coord();
				v.pz   = rand_coord();
				v.nx   = rand_coord();
				v.ny   = rand_coord();
				v.nz   = rand_coord();
				v.last = ($urandom_range(15) == 0);
				send_vertex(v, transform_vertex(v));
			end
		end
		finish_phase();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
